// ----- src/vate_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vate_pkg
// shared opcodes, sine table and fixed-point helpers
// ----------------------------------------------------------------------------
package vate_pkg;

  typedef enum logic [3:0] {
    OP_BOX    = 4'd0,
    OP_TRANS  = 4'd1,
    OP_ROTX   = 4'd2,
    OP_ROTY   = 4'd3,
    OP_ROTZ   = 4'd4,
    OP_PROTX  = 4'd5,
    OP_PROTY  = 4'd6,
    OP_PROTZ  = 4'd7,
    OP_REFX   = 4'd8,
    OP_REFY   = 4'd9,
    OP_REFZ   = 4'd10,
    OP_SHRX   = 4'd11,
    OP_SHRY   = 4'd12,
    OP_SHRZ   = 4'd13,
    OP_SCALE  = 4'd14,
    OP_READ   = 4'd15
  } op_e;

  // pass kinds executed by the datapath
  typedef enum logic [2:0] {
    PK_BOX, PK_ADD, PK_ROT, PK_REF, PK_SHR, PK_SCL, PK_NONE, PK_SUB
  } pass_e;

  typedef struct packed {
    pass_e       kind;
    logic [1:0]  axis;
    logic [31:0] ka;
    logic [31:0] kb;
    logic [31:0] kc;
    logic [31:0] sin_v;
    logic [31:0] cos_v;
  } pass_t;

  typedef logic [90:0][30:0] sin_tab_t;

  // sin(k deg) in Q2.30, k = 0..90, evaluated at elaboration
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t t;
    logic [63:0] x, m;
    logic signed [63:0] s;
    begin
      t = '0;
      for (int k = 0; k <= 90; k++) begin
        x = (64'(k) * 64'd3373259426 + 64'd90) / 64'd180;
        m = x;
        s = $signed(x);
        for (int n = 1; n <= 8; n++) begin
          m = (m * x) >> 30;
          m = (m * x) >> 30;
          m = m / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) s = s - $signed(m);
          else s = s + $signed(m);
        end
        if (s < 0) s = 0;
        if (s > 64'sd1073741824) s = 64'sd1073741824;
        t[k] = s[30:0];
      end
      build_sin_tab = t;
    end
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  // signed sine of a reduced angle 0..359 in Q2.30
  function automatic logic signed [31:0] sin_deg(input logic [8:0] a);
    logic [1:0] q;
    logic [6:0] r;
    logic [30:0] v;
    begin
      if (a >= 9'd270) begin q = 2'd3; r = 7'(a - 9'd270); end
      else if (a >= 9'd180) begin q = 2'd2; r = 7'(a - 9'd180); end
      else if (a >= 9'd90) begin q = 2'd1; r = 7'(a - 9'd90); end
      else begin q = 2'd0; r = 7'(a); end
      v = q[0] ? SIN_TAB[7'(7'd90 - r)] : SIN_TAB[r];
      sin_deg = q[1] ? -$signed({1'b0, v}) : $signed({1'b0, v});
    end
  endfunction

  function automatic logic [31:0] sat32(input logic signed [49:0] v);
    begin
      if (v > 50'sh07FFFFFFF) sat32 = 32'h7FFFFFFF;
      else if (v < -50'sh080000000) sat32 = 32'h80000000;
      else sat32 = v[31:0];
    end
  endfunction

  // product rounded to nearest, ties up
  function automatic logic signed [47:0] rnd(input logic signed [63:0] p,
                                             input logic sh30);
    logic signed [63:0] t;
    begin
      if (sh30) begin
        t = (p + 64'sd536870912) >>> 30;
      end else begin
        t = (p + 64'sd32768) >>> 16;
      end
      rnd = t[47:0];
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/vertex_affine_transform_engine.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_affine_transform_engine
// eight-vertex box store with per-operation homogeneous transform
// ----------------------------------------------------------------------------
//  channel | signals                                   | direction
//  in      | in_valid_i in_stall_o opcode_i arg_*_i ... | consumer
//  out     | out_valid_o out_stall_i vertex_index_o ... | producer
//
//  a read is a dump alone; any other operation is one to three passes over
//  the vertex memory; each pass streams one vertex per cycle through a read,
//  a multiply stage and a write back; the dump pass then emits
//  min(VERTICES, 8) words, one per accepted output cycle
//  reset clears the vertex memory by a sweep over every address
//  in_stall_o is high whenever an operation or the reset sweep is in progress
//  output stall holds the current word and pauses the dump read
module vertex_affine_transform_engine
  import vate_pkg::*;
#(
  parameter int VERTICES = 8
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [31:0] arg_a_i,
  input  wire logic [31:0] arg_b_i,
  input  wire logic [31:0] arg_c_i,
  input  wire logic [8:0]  angle_deg_i,
  input  wire logic [31:0] pivot_x_i,
  input  wire logic [31:0] pivot_y_i,
  input  wire logic [31:0] pivot_z_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic      [2:0]  vertex_index_o,
  output logic      [31:0] out_x_o,
  output logic      [31:0] out_y_o,
  output logic      [31:0] out_z_o,
  output logic             last_vertex_o
);

  localparam int AW   = (VERTICES > 1) ? $clog2(VERTICES) : 1;
  localparam int CW   = $clog2(VERTICES + 4);
  localparam int NOUT = (VERTICES < 8) ? VERTICES : 8;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_PASS, ST_DUMP, ST_DONE
  } state_e;

  state_e state_q, state_d;

  // vertex memory
  logic [95:0] mem [VERTICES];
  logic [95:0] rd_q;
  logic        we;
  logic        re;
  logic [AW-1:0] wa, ra;
  logic [95:0] wd;

  // operation registers
  logic [3:0]  op_q;
  logic [31:0] a_q, b_q, c_q, px_q, py_q, pz_q;
  logic signed [31:0] sin_q, cos_q;
  logic [1:0]  pass_q, pass_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [8:0]  ang_red;

  pass_t cur;
  logic [31:0] ax, ay, az;
  logic        alu_en;

  // pipeline tags: valid/address at read (t1) and at write (t2)
  logic          v1_q, v2_q;
  logic [AW-1:0] a1_q, a2_q;

  // output register
  logic          ov_q;
  logic [2:0]    oi_q;
  logic [95:0]   od_q;
  logic          ol_q;
  logic          dv_q;
  logic [2:0]    di_q;

  assign ang_red = (angle_deg_i >= 9'd360) ? 9'(angle_deg_i - 9'd360) : angle_deg_i;

  // pass selection: pivot ops run subtract(p), rotate, add(p)
  always_comb begin
    cur = '0;
    cur.sin_v = sin_q;
    cur.cos_v = cos_q;
    cur.axis  = 2'd0;
    cur.kind  = PK_NONE;
    cur.ka = a_q; cur.kb = b_q; cur.kc = c_q;
    case (op_e'(op_q))
      OP_BOX:   cur.kind = PK_BOX;
      OP_TRANS: cur.kind = PK_ADD;
      OP_ROTX, OP_ROTY, OP_ROTZ: begin
        cur.kind = PK_ROT;
        cur.axis = 2'(op_q - 4'd2);
      end
      OP_PROTX, OP_PROTY, OP_PROTZ: begin
        cur.axis = 2'(op_q - 4'd5);
        if (pass_q == 2'd1) cur.kind = PK_ROT;
        else begin
          // subtracting in the datapath keeps the negated minimum exact
          cur.kind = (pass_q == 2'd0) ? PK_SUB : PK_ADD;
          cur.ka = px_q;
          cur.kb = py_q;
          cur.kc = pz_q;
        end
      end
      OP_REFX, OP_REFY, OP_REFZ: begin
        cur.kind = PK_REF;
        cur.axis = 2'(op_q - 4'd8);
      end
      OP_SHRX, OP_SHRY, OP_SHRZ: begin
        cur.kind = PK_SHR;
        cur.axis = 2'(op_q - 4'd11);
      end
      OP_SCALE: cur.kind = PK_SCL;
      default:  cur.kind = PK_NONE;
    endcase
  end

  assign alu_en = 1'b1;

  vate_alu u_alu (
    .clk_i  (clk_i),
    .en_i   (alu_en),
    .pass_i (cur),
    .vidx_i (6'(a1_q)),
    .x_i    (rd_q[95:64]),
    .y_i    (rd_q[63:32]),
    .z_i    (rd_q[31:0]),
    .x_o    (ax),
    .y_o    (ay),
    .z_o    (az)
  );

  // memory; the read port holds its data while the output is stalled
  assign re = !(ov_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    if (re) rd_q <= mem[ra];
  end

  always_comb begin
    we = 1'b0;
    wa = a2_q;
    wd = {ax, ay, az};
    ra = cnt_q[AW-1:0];
    if (state_q == ST_CLEAR) begin
      we = 1'b1;
      wa = cnt_q[AW-1:0];
      wd = '0;
    end else if (state_q == ST_PASS && v2_q) begin
      we = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    pass_d  = pass_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(VERTICES - 1)) begin
          state_d = ST_IDLE;
          cnt_d = '0;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          cnt_d = '0;
          pass_d = '0;
          state_d = (opcode_i == OP_READ) ? ST_DUMP : ST_PASS;
        end
      end
      ST_PASS: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(VERTICES + 2)) begin
          cnt_d = '0;
          if (op_q >= OP_PROTX && op_q <= OP_PROTZ && pass_q != 2'd2) begin
            pass_d = pass_q + 2'd1;
          end else begin
            state_d = ST_DUMP;
          end
        end
      end
      ST_DUMP: begin
        if (!(ov_q && out_stall_i)) begin
          cnt_d = cnt_q + 1'b1;
          if (cnt_q == CW'(NOUT - 1)) state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ov_q && !dv_q) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      pass_q  <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      ov_q    <= 1'b0;
      dv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pass_q  <= pass_d;
      v1_q    <= (state_q == ST_PASS) && (cnt_q < CW'(VERTICES));
      v2_q    <= v1_q;
      // dump: read issued this cycle, data lands next cycle in rd_q
      if (state_q == ST_DUMP && !(ov_q && out_stall_i)) dv_q <= 1'b1;
      else if (!(ov_q && out_stall_i)) dv_q <= 1'b0;
      if (!(ov_q && out_stall_i)) ov_q <= dv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q <= cnt_q[AW-1:0];
    a2_q <= a1_q;
    if (!(ov_q && out_stall_i)) begin
      di_q <= cnt_q[2:0];
      oi_q <= di_q;
      od_q <= rd_q;
      ol_q <= (di_q == 3'(NOUT - 1));
    end
    if (state_q == ST_IDLE && in_valid_i) begin
      op_q <= opcode_i;
      a_q  <= arg_a_i;
      b_q  <= arg_b_i;
      c_q  <= arg_c_i;
      px_q <= pivot_x_i;
      py_q <= pivot_y_i;
      pz_q <= pivot_z_i;
      sin_q <= sin_deg(ang_red);
      cos_q <= sin_deg((ang_red >= 9'd270) ? 9'(ang_red - 9'd270) : 9'(ang_red + 9'd90));
    end
  end

  assign out_valid_o    = ov_q;
  assign vertex_index_o = oi_q;
  assign out_x_o        = od_q[95:64];
  assign out_y_o        = od_q[63:32];
  assign out_z_o        = od_q[31:0];
  assign last_vertex_o  = ol_q;

  // a stall holds the dump read, so rd_q must stay put while stalled
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PASS) |-> in_stall_o)
    else $error("input accepted mid pass");
  a_nowr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (state_q == ST_PASS || state_q == ST_CLEAR))
    else $error("memory write outside pass");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_vertex_o && !out_stall_i) |=> !out_valid_o)
    else $error("word after last vertex");

endmodule
`default_nettype wire

// ----- src/vate_alu.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vate_alu
// per-vertex pass unit: registered products, then rounding and saturation
// ----------------------------------------------------------------------------
module vate_alu
  import vate_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  pass_t            pass_i,
  input  wire logic [5:0]  vidx_i,
  input  wire logic [31:0] x_i,
  input  wire logic [31:0] y_i,
  input  wire logic [31:0] z_i,
  output logic      [31:0] x_o,
  output logic      [31:0] y_o,
  output logic      [31:0] z_o
);

  logic signed [63:0] p_q [6];
  logic signed [63:0] p_d [6];
  logic [31:0] x1_q, y1_q, z1_q;
  logic signed [31:0] ax, ay, az;
  pass_t pk_q;
  logic [5:0] vi_q;
  logic signed [49:0] rx, ry, rz;

  assign ax = $signed(x_i);
  assign ay = $signed(y_i);
  assign az = $signed(z_i);

  // stage 1: products
  always_comb begin
    for (int i = 0; i < 6; i++) p_d[i] = '0;
    case (pass_i.kind)
      PK_ROT: begin
        case (pass_i.axis)
          2'd0: begin
            p_d[0] = ay * $signed(pass_i.cos_v); p_d[1] = az * $signed(pass_i.sin_v);
            p_d[2] = ay * $signed(pass_i.sin_v); p_d[3] = az * $signed(pass_i.cos_v);
          end
          2'd1: begin
            p_d[0] = ax * $signed(pass_i.cos_v); p_d[1] = az * $signed(pass_i.sin_v);
            p_d[2] = az * $signed(pass_i.cos_v); p_d[3] = ax * $signed(pass_i.sin_v);
          end
          default: begin
            p_d[0] = ax * $signed(pass_i.cos_v); p_d[1] = ay * $signed(pass_i.sin_v);
            p_d[2] = ax * $signed(pass_i.sin_v); p_d[3] = ay * $signed(pass_i.cos_v);
          end
        endcase
      end
      PK_SHR: begin
        case (pass_i.axis)
          2'd0: begin
            p_d[0] = ay * $signed(pass_i.ka); p_d[1] = az * $signed(pass_i.kb);
          end
          2'd1: begin
            p_d[0] = ax * $signed(pass_i.ka); p_d[1] = az * $signed(pass_i.kb);
          end
          default: begin
            p_d[0] = ax * $signed(pass_i.ka); p_d[1] = ay * $signed(pass_i.kb);
          end
        endcase
      end
      PK_SCL: begin
        p_d[0] = ax * $signed(pass_i.ka);
        p_d[1] = ay * $signed(pass_i.kb);
        p_d[2] = az * $signed(pass_i.kc);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 6; i++) p_q[i] <= p_d[i];
      x1_q <= x_i;
      y1_q <= y_i;
      z1_q <= z_i;
      pk_q <= pass_i;
      vi_q <= vidx_i;
    end
  end

  // stage 2: rounding, sums, saturation (combinational into the write port)
  always_comb begin
    rx = 50'($signed(x1_q));
    ry = 50'($signed(y1_q));
    rz = 50'($signed(z1_q));
    case (pk_q.kind)
      PK_BOX: begin
        // vertices past the eighth are zero
        rx = (vi_q == 6'd1 || vi_q == 6'd2 || vi_q == 6'd5 || vi_q == 6'd6) ?
             50'($signed(pk_q.ka)) : '0;
        ry = (vi_q == 6'd2 || vi_q == 6'd3 || vi_q == 6'd6 || vi_q == 6'd7) ?
             50'($signed(pk_q.kc)) : '0;
        rz = (vi_q[5:3] == 3'd0 && vi_q[2]) ? 50'($signed(pk_q.kb)) : '0;
      end
      PK_ADD: begin
        rx = rx + 50'($signed(pk_q.ka));
        ry = ry + 50'($signed(pk_q.kb));
        rz = rz + 50'($signed(pk_q.kc));
      end
      PK_SUB: begin
        rx = rx - 50'($signed(pk_q.ka));
        ry = ry - 50'($signed(pk_q.kb));
        rz = rz - 50'($signed(pk_q.kc));
      end
      PK_ROT: begin
        case (pk_q.axis)
          2'd0: begin
            ry = 50'(rnd(p_q[0], 1'b1)) - 50'(rnd(p_q[1], 1'b1));
            rz = 50'(rnd(p_q[2], 1'b1)) + 50'(rnd(p_q[3], 1'b1));
          end
          2'd1: begin
            rx = 50'(rnd(p_q[0], 1'b1)) + 50'(rnd(p_q[1], 1'b1));
            rz = 50'(rnd(p_q[2], 1'b1)) - 50'(rnd(p_q[3], 1'b1));
          end
          default: begin
            rx = 50'(rnd(p_q[0], 1'b1)) - 50'(rnd(p_q[1], 1'b1));
            ry = 50'(rnd(p_q[2], 1'b1)) + 50'(rnd(p_q[3], 1'b1));
          end
        endcase
      end
      PK_REF: begin
        if (pk_q.axis != 2'd0) rx = -rx;
        if (pk_q.axis != 2'd1) ry = -ry;
        if (pk_q.axis != 2'd2) rz = -rz;
      end
      PK_SHR: begin
        case (pk_q.axis)
          2'd0: rx = rx + 50'(rnd(p_q[0], 1'b0)) + 50'(rnd(p_q[1], 1'b0));
          2'd1: ry = ry + 50'(rnd(p_q[0], 1'b0)) + 50'(rnd(p_q[1], 1'b0));
          default: rz = rz + 50'(rnd(p_q[0], 1'b0)) + 50'(rnd(p_q[1], 1'b0));
        endcase
      end
      PK_SCL: begin
        rx = 50'(rnd(p_q[0], 1'b0));
        ry = 50'(rnd(p_q[1], 1'b0));
        rz = 50'(rnd(p_q[2], 1'b0));
      end
      default: ;
    endcase
    x_o = sat32(rx);
    y_o = sat32(ry);
    z_o = sat32(rz);
  end

endmodule
`default_nettype wire

// ----- tb/vertex_affine_transform_engine_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_affine_transform_engine_checker
// watches both channels, predicts the vertex dump of every operation and
// compares each emitted word against the oldest prediction
// ----------------------------------------------------------------------------
module vertex_affine_transform_engine_checker
  import vate_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  input  wire logic        in_stall_i,
  input  wire logic [3:0]  opcode_i,
  input  wire logic [31:0] arg_a_i,
  input  wire logic [31:0] arg_b_i,
  input  wire logic [31:0] arg_c_i,
  input  wire logic [8:0]  angle_deg_i,
  input  wire logic [31:0] pivot_x_i,
  input  wire logic [31:0] pivot_y_i,
  input  wire logic [31:0] pivot_z_i,
  input  wire logic        out_valid_i,
  input  wire logic        out_stall_i,
  input  wire logic [2:0]  vertex_index_i,
  input  wire logic [31:0] out_x_i,
  input  wire logic [31:0] out_y_i,
  input  wire logic [31:0] out_z_i,
  input  wire logic        last_vertex_i,
  output int               errors_o,
  output int               pending_o
);

  localparam int NUM_VERTS = 8;

  typedef struct {
    logic [2:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        last;
  } vertex_word_t;

  longint            quarter_sine[91];
  logic signed [31:0] vert_x[NUM_VERTS];
  logic signed [31:0] vert_y[NUM_VERTS];
  logic signed [31:0] vert_z[NUM_VERTS];
  vertex_word_t      dump_q[$];

  assign pending_o = dump_q.size();

  // quarter-wave sine in Q2.30 from a truncated Taylor series
  initial begin
    longint unsigned xr, mag;
    longint          acc;
    for (int k = 0; k <= 90; k++) begin
      xr = (longint'(k) * 64'd3373259426 + 64'd90) / 64'd180;
      mag = xr;
      acc = longint'(xr);
      for (int n = 1; n <= 8; n++) begin
        mag = (mag * xr) >> 30;
        mag = (mag * xr) >> 30;
        mag = mag / longint'((2 * n) * (2 * n + 1));
        acc = (n % 2 == 1) ? acc - longint'(mag) : acc + longint'(mag);
      end
      if (acc < 0) acc = 0;
      if (acc > 64'sd1073741824) acc = 64'sd1073741824;
      quarter_sine[k] = acc;
    end
  end

  function automatic longint sine_of(input int unsigned deg);
    int unsigned q, r;
    longint      v;
    deg = deg % 360;
    q = deg / 90;
    r = deg % 90;
    v = q[0] ? quarter_sine[90 - r] : quarter_sine[r];
    return (q >= 2) ? -v : v;
  endfunction

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // product rounded to nearest, ties toward +inf
  function automatic longint round_mul(input longint a, input longint b, input int sh);
    longint p;
    p = a * b + (64'sd1 <<< (sh - 1));
    return p >>> sh;
  endfunction

  function automatic void shift_all(input longint tx, input longint ty, input longint tz);
    for (int i = 0; i < NUM_VERTS; i++) begin
      vert_x[i] = clamp32(longint'(vert_x[i]) + tx);
      vert_y[i] = clamp32(longint'(vert_y[i]) + ty);
      vert_z[i] = clamp32(longint'(vert_z[i]) + tz);
    end
  endfunction

  function automatic void turn_all(input int axis, input int unsigned deg);
    longint s, c, x, y, z;
    s = sine_of(deg);
    c = sine_of((deg % 360) + 90);
    for (int i = 0; i < NUM_VERTS; i++) begin
      x = vert_x[i];
      y = vert_y[i];
      z = vert_z[i];
      case (axis)
        0: begin
          vert_y[i] = clamp32(round_mul(y, c, 30) - round_mul(z, s, 30));
          vert_z[i] = clamp32(round_mul(y, s, 30) + round_mul(z, c, 30));
        end
        1: begin
          vert_x[i] = clamp32(round_mul(x, c, 30) + round_mul(z, s, 30));
          vert_z[i] = clamp32(round_mul(z, c, 30) - round_mul(x, s, 30));
        end
        default: begin
          vert_x[i] = clamp32(round_mul(x, c, 30) - round_mul(y, s, 30));
          vert_y[i] = clamp32(round_mul(x, s, 30) + round_mul(y, c, 30));
        end
      endcase
    end
  endfunction

  // applies one operation to the vertex set and queues the resulting dump
  function automatic void predict_dump(input op_e op, input longint a, input longint b,
                                       input longint c, input int unsigned deg,
                                       input longint px, input longint py, input longint pz);
    longint       x, y, z;
    vertex_word_t w;
    case (op)
      OP_BOX: begin
        for (int i = 0; i < NUM_VERTS; i++) begin
          vert_x[i] = (i == 1 || i == 2 || i == 5 || i == 6) ? a[31:0] : 32'sd0;
          vert_y[i] = (i == 2 || i == 3 || i == 6 || i == 7) ? c[31:0] : 32'sd0;
          vert_z[i] = (i >= 4) ? b[31:0] : 32'sd0;
        end
      end
      OP_TRANS: shift_all(a, b, c);
      OP_ROTX, OP_ROTY, OP_ROTZ: turn_all(int'(op) - int'(OP_ROTX), deg);
      OP_PROTX, OP_PROTY, OP_PROTZ: begin
        shift_all(-px, -py, -pz);
        turn_all(int'(op) - int'(OP_PROTX), deg);
        shift_all(px, py, pz);
      end
      OP_REFX, OP_REFY, OP_REFZ: begin
        for (int i = 0; i < NUM_VERTS; i++) begin
          if (op != OP_REFX) vert_x[i] = clamp32(-longint'(vert_x[i]));
          if (op != OP_REFY) vert_y[i] = clamp32(-longint'(vert_y[i]));
          if (op != OP_REFZ) vert_z[i] = clamp32(-longint'(vert_z[i]));
        end
      end
      OP_SHRX, OP_SHRY, OP_SHRZ: begin
        for (int i = 0; i < NUM_VERTS; i++) begin
          x = vert_x[i];
          y = vert_y[i];
          z = vert_z[i];
          if (op == OP_SHRX) vert_x[i] = clamp32(x + round_mul(y, a, 16) + round_mul(z, b, 16));
          else if (op == OP_SHRY) vert_y[i] = clamp32(y + round_mul(x, a, 16) + round_mul(z, b, 16));
          else vert_z[i] = clamp32(z + round_mul(x, a, 16) + round_mul(y, b, 16));
        end
      end
      OP_SCALE: begin
        for (int i = 0; i < NUM_VERTS; i++) begin
          vert_x[i] = clamp32(round_mul(vert_x[i], a, 16));
          vert_y[i] = clamp32(round_mul(vert_y[i], b, 16));
          vert_z[i] = clamp32(round_mul(vert_z[i], c, 16));
        end
      end
      default: ; // read leaves the set as it is
    endcase
    for (int i = 0; i < NUM_VERTS; i++) begin
      w.idx  = i[2:0];
      w.x    = vert_x[i];
      w.y    = vert_y[i];
      w.z    = vert_z[i];
      w.last = (i == NUM_VERTS - 1);
      dump_q.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors_o++;
  endtask

  initial errors_o = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_word_t w;
    if (!rst_ni) begin
      for (int i = 0; i < NUM_VERTS; i++) begin
        vert_x[i] = '0;
        vert_y[i] = '0;
        vert_z[i] = '0;
      end
      dump_q.delete();
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (dump_q.size() == 0) begin
          report_mismatch($sformatf("unexpected vertex word idx %0d", vertex_index_i));
        end else begin
          w = dump_q.pop_front();
          if (vertex_index_i !== w.idx)
            report_mismatch($sformatf("index %0d, want %0d", vertex_index_i, w.idx));
          if (out_x_i !== w.x)
            report_mismatch($sformatf("v%0d x %h, want %h", w.idx, out_x_i, w.x));
          if (out_y_i !== w.y)
            report_mismatch($sformatf("v%0d y %h, want %h", w.idx, out_y_i, w.y));
          if (out_z_i !== w.z)
            report_mismatch($sformatf("v%0d z %h, want %h", w.idx, out_z_i, w.z));
          if (last_vertex_i !== w.last)
            report_mismatch($sformatf("v%0d last %b, want %b", w.idx, last_vertex_i, w.last));
        end
      end
      if (in_valid_i && !in_stall_i)
        predict_dump(op_e'(opcode_i), longint'($signed(arg_a_i)), longint'($signed(arg_b_i)),
                     longint'($signed(arg_c_i)), int'(angle_deg_i),
                     longint'($signed(pivot_x_i)), longint'($signed(pivot_y_i)),
                     longint'($signed(pivot_z_i)));
    end
  end

endmodule
`default_nettype wire

// ----- tb/vertex_affine_transform_engine_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_affine_transform_engine_test
// drives box, transform and read operations into the engine with random
// gaps and output stalls; a checker beside the engine predicts every dump
// ----------------------------------------------------------------------------
module vertex_affine_transform_engine_test;
  import vate_pkg::*;

  // a quiet cycle budget far above one pivot rotation with every word stalled
  localparam int IDLE_LIMIT = 20000;
  localparam int NUM_RANDOM = 330;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [3:0]  opcode_i;
  logic [31:0] arg_a_i, arg_b_i, arg_c_i;
  logic [8:0]  angle_deg_i;
  logic [31:0] pivot_x_i, pivot_y_i, pivot_z_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [2:0]  vertex_index_o;
  logic [31:0] out_x_o, out_y_o, out_z_o;
  logic        last_vertex_o;

  int errors;
  int pending;
  bit quiet;        // no gaps and no stalls while set
  int idle_cycles;

  vertex_affine_transform_engine DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .opcode_i, .arg_a_i, .arg_b_i,
    .arg_c_i, .angle_deg_i, .pivot_x_i, .pivot_y_i, .pivot_z_i, .out_valid_o,
    .out_stall_i, .vertex_index_o, .out_x_o, .out_y_o, .out_z_o, .last_vertex_o
  );

  vertex_affine_transform_engine_checker checker_inst (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .opcode_i, .arg_a_i,
    .arg_b_i, .arg_c_i, .angle_deg_i, .pivot_x_i, .pivot_y_i, .pivot_z_i,
    .out_valid_i(out_valid_o), .out_stall_i, .vertex_index_i(vertex_index_o),
    .out_x_i(out_x_o), .out_y_i(out_y_o), .out_z_i(out_z_o),
    .last_vertex_i(last_vertex_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // mostly back to back, sometimes a few cycles, rarely a long pause
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Q16.16 value within +-span, now and then any 32-bit pattern
  function automatic logic [31:0] rand_q16(input int unsigned span);
    if ($urandom_range(0, 9) == 0) return $urandom;
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // mostly in-range angles, some past 359 to hit the wrap
  function automatic logic [8:0] rand_angle();
    if ($urandom_range(0, 4) == 0) return 9'($urandom_range(0, 511));
    return 9'($urandom_range(0, 359));
  endfunction

  // receiver stall: random bursts of stall and flow
  always @(posedge clk_i or negedge rst_ni) begin
    int hold;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold = 0;
    end else if (hold > 0) begin
      hold--;
    end else begin
      out_stall_i <= !quiet && ($urandom_range(0, 2) == 0);
      hold = gap_len();
    end
  end

  // watchdog: counts cycles where neither channel moves a word
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog expired after %0d idle cycles", IDLE_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one operation word: optional gap, then hold valid until taken
  task automatic send_op(input op_e op, input logic [31:0] a, input logic [31:0] b,
                         input logic [31:0] c, input logic [8:0] deg,
                         input logic [31:0] px, input logic [31:0] py,
                         input logic [31:0] pz);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= op;
    arg_a_i     <= a;
    arg_b_i     <= b;
    arg_c_i     <= c;
    angle_deg_i <= deg;
    pivot_x_i   <= px;
    pivot_y_i   <= py;
    pivot_z_i   <= pz;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // random operation with modest operands so chains stay meaningful
  task automatic send_random_op(input op_e op);
    logic [31:0] a, b, c;
    int unsigned span;
    span = (op == OP_SCALE) ? 32'h00020000 :
           (op >= OP_SHRX && op <= OP_SHRZ) ? 32'h00010000 : 32'h00640000;
    a = rand_q16(span);
    b = rand_q16(span);
    c = rand_q16(span);
    send_op(op, a, b, c, rand_angle(), rand_q16(32'h00640000), rand_q16(32'h00640000),
            rand_q16(32'h00640000));
  endtask

  initial begin
    op_e op;
    int  chain;
    in_valid_i  = 1'b0;
    opcode_i    = OP_READ;
    arg_a_i     = '0;
    arg_b_i     = '0;
    arg_c_i     = '0;
    angle_deg_i = '0;
    pivot_x_i   = '0;
    pivot_y_i   = '0;
    pivot_z_i   = '0;
    quiet       = 1'b0;
    idle_cycles = 0;
    rst_ni      = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: read after reset, then a box through every operation but the reflections
    send_op(OP_READ, '1, '1, '1, 9'h1FF, '1, '1, '1);
    send_op(OP_BOX, 32'h00010000, 32'h00020000, 32'h00030000, '0, '0, '0, '0);
    send_op(OP_ROTX, '0, '0, '0, 9'd90, '0, '0, '0);
    send_op(OP_ROTY, '0, '0, '0, 9'd180, '0, '0, '0);
    send_op(OP_ROTZ, '0, '0, '0, 9'd270, '0, '0, '0);
    send_op(OP_ROTZ, '0, '0, '0, 9'd359, '0, '0, '0);
    send_op(OP_ROTX, '0, '0, '0, 9'd511, '0, '0, '0);   // wraps past a turn
    send_op(OP_PROTX, '0, '0, '0, 9'd45, 32'h00010000, 32'hFFFF0000, 32'h00008000);
    send_op(OP_PROTY, '0, '0, '0, 9'd360, 32'h7FFFFFFF, 32'h80000000, '0);
    send_op(OP_PROTZ, '0, '0, '0, 9'd30, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_op(OP_TRANS, 32'h7FFFFFFF, 32'h80000000, 32'h00010000, '0, '0, '0, '0);
    send_op(OP_SHRX, 32'h00008000, 32'hFFFF8000, '0, '0, '0, '0, '0);
    send_op(OP_SHRY, 32'h7FFFFFFF, 32'h80000000, '0, '0, '0, '0, '0);
    send_op(OP_SHRZ, 32'h00010000, 32'h00010000, '0, '0, '0, '0, '0);
    send_op(OP_SCALE, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, '0, '0, '0, '0);
    // box at the extremes, then reflect on each axis, negating the minimum in x and y
    send_op(OP_BOX, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, '0, '0, '0, '0);
    send_op(OP_REFX, '0, '0, '0, '0, '0, '0, '0);
    send_op(OP_REFY, '0, '0, '0, '0, '0, '0, '0);
    send_op(OP_REFZ, '0, '0, '0, '0, '0, '0, '0);
    send_op(OP_SCALE, 32'hFFFFFFFF, 32'h00000001, 32'hFFFF8000, '0, '0, '0, '0);
    send_op(OP_READ, '0, '0, '0, '0, '0, '0, '0);

    // random: fresh boxes followed by chains of transforms, plus some noise
    for (int n = 0; n < NUM_RANDOM; n += chain + 1) begin
      if ($urandom_range(0, 7) == 0) quiet = ~quiet;
      if ($urandom_range(0, 9) == 0) begin
        send_op(op_e'($urandom_range(0, 15)), $urandom, $urandom, $urandom,
                9'($urandom), $urandom, $urandom, $urandom);
        chain = 0;
      end else begin
        send_op(OP_BOX, rand_q16(32'h00640000), rand_q16(32'h00640000),
                rand_q16(32'h00640000), rand_angle(), '0, '0, '0);
        chain = $urandom_range(1, 10);
        for (int k = 0; k < chain; k++) begin
          op = op_e'($urandom_range(1, 15));
          send_random_op(op);
        end
      end
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    // let the checker queue the last prediction before draining
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- filelist.f -----
src/vate_pkg.sv
src/vate_alu.sv
src/vertex_affine_transform_engine.sv
tb/vertex_affine_transform_engine_checker.sv
tb/vertex_affine_transform_engine_test.sv
